>>> sv/fdmd_pkg.sv
package fdmd_pkg;

  // default store depth in pixels
  localparam int unsigned MAX_PIXELS_DEF = 65536;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;
  localparam int unsigned THR_W  = 10;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // red sits in the lowest bits, as on the input bus
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CAPTURED  = 2'd0,
    ST_MOTION    = 2'd1,
    ST_NO_MOTION = 2'd2,
    ST_MISMATCH  = 2'd3
  } status_e;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_COUNT = 2'd2;

  function automatic logic [CH_W-1:0] absdiff8(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    absdiff8 = (a >= b) ? (a - b) : (b - a);
  endfunction

  // floor average of two channel values
  function automatic logic [CH_W-1:0] avg8(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    avg8 = s[CH_W:1];
  endfunction

endpackage

>>> sv/frame_difference_motion_detect.sv
// Frame-differencing motion detector. RGB pixels stream in one beat each,
// tlast marking the last pixel of a frame. The first frame after reset is
// stored as the reference and its length kept. Every later pixel is compared
// with its reference entry: if |dR|+|dG|+|dB| exceeds diff_threshold the pixel
// counts as changed, and the entry becomes the per-channel floor average of
// old and new. Only the last pixel of a frame yields an output beat: status
// (0 captured, 1 motion, 2 no motion, 3 size mismatch) and the changed count.
// Motion means min_count <= count <= max_count. On a length mismatch pixels
// past the reference length are skipped; pixels past MAX_PIXELS are never
// stored. Throughput is one pixel per clock unless input stalls: the
// reference store is a single synchronous RAM read at accept and written
// back from stage 1, with forwarding for a write and a read to the same
// entry in the same cycle. A result beat is registered after stage 1 and
// the output holds one result; input stalls only while that result and a
// pending frame end both wait. No clearing pass: the capture frame writes
// every entry later frames read. Write configuration only while idle.
module frame_difference_motion_detect #(
  parameter int unsigned MAX_PIXELS = fdmd_pkg::MAX_PIXELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [fdmd_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [fdmd_pkg::CFG_W-1:0]          cfg_data_i,
  // pixel input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fdmd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // red, green, blue
  input  logic                                s_axis_tlast,   // frame_end
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fdmd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // status, changed_count, pad
);
  import fdmd_pkg::*;

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  // position/length/count width: holds MAX_PIXELS + 1
  localparam int unsigned PW = $clog2(MAX_PIXELS + 2);
  localparam int unsigned DW = (PW > CNT_W) ? PW : CNT_W;
  localparam logic [PW-1:0] LEN_CAP = PW'(MAX_PIXELS + 1);
  localparam logic [PW-1:0] MAX_LEN = PW'(MAX_PIXELS);

  // configuration
  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
        REG_MIN_COUNT: min_q <= cfg_data_i[CNT_W-1:0];
        REG_MAX_COUNT: max_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: position tracking, RAM read issue
  logic          accept;
  pixel_t        in_pix;
  logic [PW-1:0] pos_q, ref_len_q, len, limit;
  logic          ref_valid_q;
  logic          capture, cap_wr, cmp, mismatch;

  assign in_pix   = pixel_t'(s_axis_tdata[PIX_W-1:0]);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign len      = (pos_q < LEN_CAP) ? pos_q + PW'(1) : LEN_CAP;
  assign limit    = (ref_len_q > MAX_LEN) ? MAX_LEN : ref_len_q;
  assign capture  = !ref_valid_q;
  assign cap_wr   = capture && (pos_q < MAX_LEN);
  assign cmp      = ref_valid_q && (pos_q < limit);
  assign mismatch = (len != ref_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ref_len_q   <= '0;
      ref_valid_q <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        pos_q <= '0;
        if (capture) begin
          ref_valid_q <= 1'b1;
          ref_len_q   <= len;
        end
      end else begin
        pos_q <= len;
      end
    end
  end

  // stage 1 registers
  logic          s1_valid_q, s1_last_q, s1_cap_q, s1_wr_q, s1_cmp_q, s1_mis_q;
  logic [AW-1:0] s1_addr_q;
  pixel_t        s1_pix_q;
  logic          fwd_q;
  pixel_t        fwd_data_q;
  logic          s1_adv, out_free;

  // RAM ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  pixel_t        wr_data, rd_data;
  logic [AW-1:0] rd_addr;

  assign rd_addr = pos_q[AW-1:0];

  fdmd_ref_mem #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_ref_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (accept && cmp),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // payload of stage 1; forward a write landing on the entry being read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q  <= s_axis_tlast;
      s1_cap_q   <= capture;
      s1_wr_q    <= cap_wr;
      s1_cmp_q   <= cmp;
      s1_mis_q   <= mismatch;
      s1_addr_q  <= rd_addr;
      s1_pix_q   <= in_pix;
      fwd_q      <= wr_en && (wr_addr == rd_addr);
      fwd_data_q <= wr_data;
    end
  end

  // stage 1: compare, update, write back
  pixel_t            ref_pix, avg_pix;
  logic [THR_W-1:0]  diff_sum;
  logic              hit;
  logic [PW-1:0]     cnt_q, cnt_new;
  logic [DW-1:0]     cnt_ext;
  status_e           st;

  assign ref_pix  = fwd_q ? fwd_data_q : rd_data;
  assign diff_sum = THR_W'(absdiff8(s1_pix_q.red,   ref_pix.red))
                  + THR_W'(absdiff8(s1_pix_q.green, ref_pix.green))
                  + THR_W'(absdiff8(s1_pix_q.blue,  ref_pix.blue));
  assign hit      = s1_cmp_q && (diff_sum > thr_q);
  assign cnt_new  = cnt_q + PW'(hit);
  assign cnt_ext  = DW'(cnt_new);

  assign avg_pix.red   = avg8(s1_pix_q.red,   ref_pix.red);
  assign avg_pix.green = avg8(s1_pix_q.green, ref_pix.green);
  assign avg_pix.blue  = avg8(s1_pix_q.blue,  ref_pix.blue);

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  assign wr_en   = s1_adv && (s1_wr_q || s1_cmp_q);
  assign wr_addr = s1_addr_q;
  assign wr_data = s1_cap_q ? s1_pix_q : avg_pix;

  always_comb begin
    if (s1_cap_q) begin
      st = ST_CAPTURED;
    end else if (s1_mis_q) begin
      st = ST_MISMATCH;
    end else if ((cnt_ext >= DW'(min_q)) && (cnt_ext <= DW'(max_q))) begin
      st = ST_MOTION;
    end else begin
      st = ST_NO_MOTION;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s1_adv) begin
      cnt_q <= s1_last_q ? '0 : cnt_new;
    end
  end

  // output register
  logic              out_valid_q;
  logic [STAT_W-1:0] out_st_q;
  logic [CNT_W-1:0]  out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_st_q  <= st;
      out_cnt_q <= s1_cap_q ? '0 : cnt_ext[CNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_cnt_q, out_st_q});

endmodule

>>> sv/fdmd_ref_mem.sv
module fdmd_ref_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  fdmd_pkg::pixel_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output fdmd_pkg::pixel_t rd_data_o
);
  import fdmd_pkg::*;

  pixel_t mem_q [DEPTH];
  pixel_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write; the caller forwards same-address writes
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> sv/fdmd_checker.sv
module fdmd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [fdmd_pkg::IDX_W-1:0]       cfg_idx_i,
  input logic [fdmd_pkg::CFG_W-1:0]       cfg_data_i,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fdmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import fdmd_pkg::*;

  logic [CNT_W-1:0]  min_q, max_q;
  logic [STAT_W-1:0] st;
  logic [CNT_W-1:0]  cnt;

  assign st  = m_axis_tdata[STAT_W-1:0];
  assign cnt = m_axis_tdata[STAT_W+CNT_W-1:STAT_W];

  // shadow copies of the motion bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MIN_COUNT) begin
        min_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_MAX_COUNT) begin
        max_q <= cfg_data_i;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_capture_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_CAPTURED) |-> (cnt == '0))
    else $error("capture result with nonzero count");

  a_motion_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_MOTION) |-> (cnt >= min_q) && (cnt <= max_q))
    else $error("motion reported outside count bounds");

  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without preceding frame end");

endmodule

bind frame_difference_motion_detect fdmd_checker u_fdmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_data_i    (cfg_data_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
